// File: rtl/kgbr_pkg.sv
`timescale 1ns / 1ps

package kgbr_pkg;

    localparam int MAX_GROUP = 16;
    localparam int IDX_W     = $clog2(MAX_GROUP);
    localparam int CNT_W     = IDX_W + 1;
    localparam int DATA_W    = 32;
    localparam int CFG_W     = 5;
    localparam int NUM_BANKS = 2;
    localparam int BANK_W    = 1;
    localparam int ADDR_W    = BANK_W + IDX_W;
    localparam int CMD_DEPTH = 2;

    // one closed group handed from the front to the back
    typedef struct packed {
        logic [BANK_W-1:0] bank;
        logic [CNT_W-1:0]  n;
        logic              rev;
        logic              last;
    } cmd_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
    } wr_t;

    typedef struct packed {
        logic              valid;
        logic [BANK_W-1:0] bank;
    } rel_t;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              run_last;
        logic              list_end;
    } res_t;

endpackage

// File: rtl/kgbr_if.sv
`timescale 1ns / 1ps

interface kgbr_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] value;
    logic               list_last;

    modport source (output valid, output value, output list_last, input ready);
    modport sink (input valid, input value, input list_last, output ready);
endinterface

interface kgbr_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] out_value;
    logic               run_last;
    logic               list_end;

    modport source (output valid, output out_value, output run_last, output list_end,
                    input ready);
    modport sink (input valid, input out_value, input run_last, input list_end,
                  output ready);
endinterface

// File: rtl/kgbr_cmd_fifo.sv
`timescale 1ns / 1ps

module kgbr_cmd_fifo
    import kgbr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    output logic push_ready,
    input  cmd_t push_data,
    output logic pop_valid,
    input  logic pop_ready,
    output cmd_t pop_data
);

    localparam int PTR_W = $clog2(CMD_DEPTH);

    cmd_t               ent_reg [CMD_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]     cnt_reg, cnt_next;
    logic               push, pop;

    assign push_ready = (cnt_reg != (PTR_W+1)'(CMD_DEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign pop_data   = ent_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(CMD_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(CMD_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: rtl/kgbr_front.sv
`timescale 1ns / 1ps

module kgbr_front
    import kgbr_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_wdata,
    kgbr_in_if.sink          in_ch,
    output wr_t              wr,
    output logic             cmd_valid,
    input  logic             cmd_ready,
    output cmd_t             cmd,
    input  rel_t             rel
);

    logic [CFG_W-1:0]     group_size_reg;
    logic [CNT_W-1:0]     fill_reg, fill_next;
    logic [BANK_W-1:0]    wb_reg, wb_next;
    logic [NUM_BANKS-1:0] busy_reg, busy_next;
    logic [CNT_W-1:0]     k;
    logic [CNT_W-1:0]     fill_inc;
    logic                 acc, full_grp, close;

    // effective group size: zero acts as one, large values saturate
    always_comb
    begin
        priority if (group_size_reg == '0)
        begin
            k = CNT_W'(1);
        end
        else if (int'(group_size_reg) > MAX_GROUP)
        begin
            k = CNT_W'(MAX_GROUP);
        end
        else
        begin
            k = CNT_W'(group_size_reg);
        end
    end

    assign in_ch.ready = !busy_reg[wb_reg] && cmd_ready;
    assign acc         = in_ch.valid && in_ch.ready;
    assign fill_inc    = fill_reg + 1'b1;
    assign full_grp    = (fill_inc >= k);
    assign close       = acc && (full_grp || in_ch.list_last);

    assign wr.en   = acc;
    assign wr.addr = {wb_reg, fill_reg[IDX_W-1:0]};
    assign wr.data = in_ch.value;

    assign cmd_valid = close;
    assign cmd.bank  = wb_reg;
    assign cmd.n     = fill_inc;
    assign cmd.rev   = full_grp;
    assign cmd.last  = in_ch.list_last;

    always_comb
    begin
        fill_next = fill_reg;
        wb_next   = wb_reg;
        busy_next = busy_reg;
        if (rel.valid)
        begin
            busy_next[rel.bank] = 1'b0;
        end
        if (close)
        begin
            busy_next[wb_reg] = 1'b1;
            wb_next           = wb_reg + 1'b1;
            fill_next         = '0;
        end
        else if (acc)
        begin
            fill_next = fill_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_size_reg <= CFG_W'(1);
            fill_reg       <= '0;
            wb_reg         <= '0;
            busy_reg       <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                group_size_reg <= cfg_wdata;
            end
            fill_reg <= fill_next;
            wb_reg   <= wb_next;
            busy_reg <= busy_next;
        end
    end

endmodule

// File: rtl/kgbr_back.sv
`timescale 1ns / 1ps

module kgbr_back
    import kgbr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  wr_t        wr,
    input  logic       cmd_valid,
    output logic       cmd_ready,
    input  cmd_t       cmd,
    output rel_t       rel,
    kgbr_out_if.source out_ch
);

    logic [DATA_W-1:0] mem [NUM_BANKS*MAX_GROUP];

    cmd_t              cur_reg;
    logic              active_reg;
    logic [IDX_W-1:0]  j_reg;
    logic              pend_reg;
    logic [DATA_W-1:0] rd_data_reg;
    logic              rd_rl_reg, rd_le_reg;
    res_t              ent_reg [2];
    logic              ohead_reg;
    logic [1:0]        ocnt_reg, ocnt_next;

    logic [IDX_W-1:0]  last_idx, idx;
    logic [ADDR_W-1:0] rd_addr;
    logic [1:0]        occ_after;
    logic              pop, issue, final_one, load;
    logic              tail;

    assign pop       = out_ch.valid && out_ch.ready;
    // slots taken once this cycle settles, counting the read in flight
    assign occ_after = ocnt_reg + {1'b0, pend_reg} - {1'b0, pop};
    assign issue     = active_reg && (occ_after < 2'd2);
    assign last_idx  = IDX_W'(cur_reg.n - 1'b1);
    assign final_one = (j_reg == last_idx);
    assign idx       = cur_reg.rev ? (last_idx - j_reg) : j_reg;
    assign rd_addr   = {cur_reg.bank, idx};
    assign cmd_ready = !active_reg || (issue && final_one);
    assign load      = cmd_valid && cmd_ready;

    assign rel.valid = issue && final_one;
    assign rel.bank  = cur_reg.bank;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (issue)
        begin
            rd_data_reg <= mem[rd_addr];
            rd_rl_reg   <= final_one;
            rd_le_reg   <= final_one && cur_reg.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            j_reg      <= '0;
            pend_reg   <= 1'b0;
        end
        else
        begin
            pend_reg <= issue;
            if (load)
            begin
                active_reg <= 1'b1;
                j_reg      <= '0;
            end
            else if (issue && final_one)
            begin
                active_reg <= 1'b0;
            end
            else if (issue)
            begin
                j_reg <= j_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cur_reg <= cmd;
        end
    end

    // two-entry result queue behind the registered read
    assign tail         = ohead_reg ^ ocnt_reg[0];
    assign out_ch.valid     = (ocnt_reg != 2'd0);
    assign out_ch.out_value = ent_reg[ohead_reg].value;
    assign out_ch.run_last  = ent_reg[ohead_reg].run_last;
    assign out_ch.list_end  = ent_reg[ohead_reg].list_end;

    always_comb
    begin
        ocnt_next = ocnt_reg + {1'b0, pend_reg} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (pend_reg)
        begin
            ent_reg[tail] <= '{value: rd_data_reg, run_last: rd_rl_reg, list_end: rd_le_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ohead_reg <= 1'b0;
            ocnt_reg  <= 2'd0;
        end
        else
        begin
            ohead_reg <= ohead_reg ^ pop;
            ocnt_reg  <= ocnt_next;
        end
    end

endmodule

// File: rtl/k_group_block_reverser.sv
`timescale 1ns / 1ps
// k_group_block_reverser: reverses a streamed list in full groups of group_size elements.
// in_ch carries one list element per transaction, list_last on the final one.
// out_ch carries the reordered elements; run_last ends the results of one group,
// list_end marks the final element of the whole list. A short last group keeps its order.
// cfg_we/cfg_wdata write group_size (0 acts as 1, values above 16 saturate at 16);
// write it only while the block is idle.
// The front stores elements into one of two 16-entry banks and, when a group
// closes (full, or list ends), queues a command and switches banks. The back
// reads the closed bank one element per cycle while its result queue has room.
// Throughput: one input per cycle while the bank being filled is free and the command
// queue has room; a group of n elements drains at one element per cycle while the
// result queue has room. In a steady stream the front stalls every second group until
// the back releases the bank it refills. With the back idle, the first result of a
// group passes through the command queue, the back's command register, the registered
// read and the result queue before it is valid on out_ch.
// Reset clears the fill count, both bank busy flags, the queues, and sets
// group_size to 1. A stalled receiver fills the two-entry result queue, then the
// back stops reading, both banks become busy and in_ch.ready drops.
module k_group_block_reverser
    import kgbr_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_wdata,
    kgbr_in_if.sink          in_ch,
    kgbr_out_if.source       out_ch
);

    wr_t  wr;
    rel_t rel;
    cmd_t push_cmd, pop_cmd;
    logic push_valid, push_ready, pop_valid, pop_ready;

    kgbr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_ch),
        .wr        (wr),
        .cmd_valid (push_valid),
        .cmd_ready (push_ready),
        .cmd       (push_cmd),
        .rel       (rel)
    );

    kgbr_cmd_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_cmd)
    );

    kgbr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr        (wr),
        .cmd_valid (pop_valid),
        .cmd_ready (pop_ready),
        .cmd       (pop_cmd),
        .rel       (rel),
        .out_ch    (out_ch)
    );

    a_list_end_closes_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.list_end |-> out_ch.run_last)
        else $error("list_end without run_last");

    a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        push_valid |-> push_ready)
        else $error("group closed with command queue full");

    a_group_len: assert property (@(posedge clk) disable iff (!rst_n)
        push_valid |-> (push_cmd.n != '0) && (push_cmd.n <= CNT_W'(MAX_GROUP)))
        else $error("group length out of range");

    a_write_not_released_bank: assert property (@(posedge clk) disable iff (!rst_n)
        wr.en && rel.valid |-> wr.addr[ADDR_W-1 -: BANK_W] != rel.bank)
        else $error("write into bank still being drained");

endmodule
